// ===== src/dss_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dss_pkg
// Shared types and constants for the dual-stack shared buffer.
// ============================================================================
package dss_pkg;

    localparam int SIZE_W    = 9;   // width of size and capacity fields
    localparam int XDATA_W   = 32;  // width of data on the stream ports
    localparam int PADDR_W   = 3;   // one 32-bit register, word index in bit 2
    localparam int PDATA_W   = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    // register word index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

// ===== src/dss_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dss_mem
// Single-port element store, one access per cycle, registered read data.
// ============================================================================
module dss_mem #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic              clk,
    input  dss_pkg::mem_cmd_t cmd,
    input  logic [AW-1:0]     addr,
    input  logic [DW-1:0]     wdata,
    output logic [DW-1:0]     rdata
);

    logic [DW-1:0] store [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store[addr] <= wdata;
        end
    end

    // read data holds until the next read, so a stalled result keeps it
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dss_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dss_ctrl
// Stack counters, capacity register, request decode and result status.
// ============================================================================
module dss_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dss_pkg::PADDR_W-1:0]  paddr,
    input  logic [dss_pkg::PDATA_W-1:0]  pwdata,
    output logic [dss_pkg::PDATA_W-1:0]  prdata,
    // request side
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_cmd,
    input  logic                         in_sel,
    // result side
    output logic                         out_valid,
    input  logic                         out_ready,
    output dss_pkg::status_t             out_status,
    output logic [dss_pkg::SIZE_W-1:0]   out_size_one,
    output logic [dss_pkg::SIZE_W-1:0]   out_size_two,
    output logic                         out_full,
    output logic                         out_rd_sel,
    // memory
    output dss_pkg::mem_cmd_t            mem_cmd,
    output logic [$clog2(DEPTH)-1:0]     mem_addr
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CAPW = $clog2(DEPTH + 1);
    localparam logic [CAPW-1:0] CAP_MAX = CAPW'(DEPTH);

    logic [CAPW-1:0]  cap_reg,  cap_next;
    logic [CAPW-1:0]  cnt1_reg, cnt1_next;
    logic [CAPW-1:0]  cnt2_reg, cnt2_next;
    logic             valid_reg, valid_next;
    logic             rdsel_reg, rdsel_next;
    dss_pkg::status_t status_reg, status_next;

    logic             in_fire;
    logic             cfg_wr;
    logic [dss_pkg::SIZE_W-1:0] cfg_val;
    logic [CAPW:0]    sum_cur;
    logic [CAPW:0]    sum_new;
    logic             full_cur;
    logic [CAPW-1:0]  pos;
    dss_pkg::cmd_t    cmd;

    assign cmd      = dss_pkg::cmd_t'(in_cmd);
    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign sum_cur  = {1'b0, cnt1_reg} + {1'b0, cnt2_reg};
    assign full_cur = sum_cur >= {1'b0, cap_reg};

    // capacity may change only while both stacks are empty
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == dss_pkg::REG_CAPACITY)
                     && (cnt1_reg == '0) && (cnt2_reg == '0);
    assign cfg_val = pwdata[dss_pkg::SIZE_W-1:0];
    assign prdata  = dss_pkg::PDATA_W'(cap_reg);

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr)
        begin
            if (cfg_val == '0)
            begin
                cap_next = CAPW'(1);
            end
            else if (32'(cfg_val) > DEPTH)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = CAPW'(cfg_val);
            end
        end
    end

    always_comb
    begin
        cnt1_next   = cnt1_reg;
        cnt2_next   = cnt2_reg;
        status_next = status_reg;
        rdsel_next  = rdsel_reg;
        mem_cmd     = '0;
        pos         = '0;
        if (in_fire)
        begin
            status_next = dss_pkg::ST_DONE;
            rdsel_next  = 1'b0;
            case (cmd)
                dss_pkg::CMD_PUSH:
                begin
                    if (full_cur)
                    begin
                        status_next = dss_pkg::ST_FULL;
                    end
                    else if (!in_sel)
                    begin
                        pos          = cnt1_reg;
                        mem_cmd.wr_en = 1'b1;
                        cnt1_next    = cnt1_reg + 1'b1;
                    end
                    else
                    begin
                        pos          = cap_reg - cnt2_reg - 1'b1;
                        mem_cmd.wr_en = 1'b1;
                        cnt2_next    = cnt2_reg + 1'b1;
                    end
                end
                dss_pkg::CMD_POP,
                dss_pkg::CMD_PEEK:
                begin
                    if (in_sel ? (cnt2_reg == '0) : (cnt1_reg == '0))
                    begin
                        status_next = dss_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        pos           = in_sel ? (cap_reg - cnt2_reg) : (cnt1_reg - 1'b1);
                        mem_cmd.rd_en = 1'b1;
                        rdsel_next    = 1'b1;
                        if (cmd == dss_pkg::CMD_POP)
                        begin
                            if (in_sel)
                            begin
                                cnt2_next = cnt2_reg - 1'b1;
                            end
                            else
                            begin
                                cnt1_next = cnt1_reg - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // unused code: no operation, reported as done
                end
            endcase
        end
    end

    assign mem_addr = AW'(pos);

    always_comb
    begin
        valid_next = valid_reg;
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_MAX;
            cnt1_reg   <= '0;
            cnt2_reg   <= '0;
            valid_reg  <= 1'b0;
            rdsel_reg  <= 1'b0;
            status_reg <= dss_pkg::ST_DONE;
        end
        else
        begin
            cap_reg    <= cap_next;
            cnt1_reg   <= cnt1_next;
            cnt2_reg   <= cnt2_next;
            valid_reg  <= valid_next;
            rdsel_reg  <= rdsel_next;
            status_reg <= status_next;
        end
    end

    // counters hold the sizes after the last request until the next one
    assign sum_new      = {1'b0, cnt1_reg} + {1'b0, cnt2_reg};
    assign out_valid    = valid_reg;
    assign out_status   = status_reg;
    assign out_size_one = dss_pkg::SIZE_W'(cnt1_reg);
    assign out_size_two = dss_pkg::SIZE_W'(cnt2_reg);
    assign out_full     = sum_new >= {1'b0, cap_reg};
    assign out_rd_sel   = rdsel_reg;

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        sum_cur <= {1'b0, cap_reg})
        else $error("stack sizes exceed capacity");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.wr_en && mem_cmd.rd_en))
        else $error("read and write issued together");

    a_access_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.wr_en || mem_cmd.rd_en) |-> in_fire)
        else $error("memory access without a request");

    a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(in_fire))
        else $error("result appeared without a request");
`endif

endmodule

// ===== src/dual_stack_shared_buffer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dual_stack_shared_buffer
// Two LIFO stacks in one shared element store, one growing up from entry 0,
// the other growing down from the top of the capacity in use.
// ============================================================================
//  port group  | dir | contents
//  s_*         | in  | request: tuser = cmd, stack_select; tdata = write_data
//  m_*         | out | result: tuser = status; tdata = read_data, sizes, full
//  p*          | in  | APB register port, capacity_in_use at address 0
//
//  One request per cycle while results are taken; its result is registered
//  in the cycle after accept, read data by the single read/write port of the store.
//  A request is accepted while the result register is empty or being taken.
//  Reset clears both stack counts and sets capacity to DEPTH; store contents
//  are not cleared and only pushed entries are ever read.
// ============================================================================
module dual_stack_shared_buffer #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dss_pkg::PADDR_W-1:0]     paddr,
    input  logic [dss_pkg::PDATA_W-1:0]     pwdata,
    output logic [dss_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dss_pkg::XDATA_W-1:0]     s_tdata,  // [31:0] write_data
    input  logic [dss_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] cmd, [2] stack_select
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dss_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] read_data,
                                                      // [40:32] size_one,
                                                      // [49:41] size_two,
                                                      // [50] buffer_full, rest 0
    output logic [dss_pkg::M_TUSER_W-1:0]   m_tuser   // [1:0] status
);

    localparam int AW = $clog2(DEPTH);

    dss_pkg::mem_cmd_t            mem_cmd;
    logic [AW-1:0]                mem_addr;
    logic [DATA_WIDTH-1:0]        mem_rdata;
    dss_pkg::status_t             status;
    logic [dss_pkg::SIZE_W-1:0]   size_one;
    logic [dss_pkg::SIZE_W-1:0]   size_two;
    logic                         full;
    logic                         rd_sel;
    logic [dss_pkg::XDATA_W-1:0]  read_data;

    assign pready = 1'b1;

    dss_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser[1:0]),
        .in_sel       (s_tuser[2]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (status),
        .out_size_one (size_one),
        .out_size_two (size_two),
        .out_full     (full),
        .out_rd_sel   (rd_sel),
        .mem_cmd      (mem_cmd),
        .mem_addr     (mem_addr)
    );

    dss_mem #(
        .AW(AW),
        .DW(DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (DATA_WIDTH'(s_tdata)),
        .rdata (mem_rdata)
    );

    // read data is zero for pushes and refused requests
    assign read_data = rd_sel ? dss_pkg::XDATA_W'(mem_rdata) : '0;

    assign m_tdata = {5'b0, full, size_two, size_one, read_data};
    assign m_tuser = status;

endmodule

// ===== sim/dual_stack_shared_buffer_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dual_stack_shared_buffer_test
// Self-checking bench for the dual-stack shared buffer. Requests go in on the
// slave stream and the capacity register is set over APB. A cycle-free model
// of both stacks predicts every result, and each result is compared field by
// field in arrival order. A directed part covers empty and full refusals, the
// unused opcode and capacity saturation. Random traffic then fills and drains
// the stacks under several sender and receiver idle patterns.
// ============================================================================
module dual_stack_shared_buffer_test;

    localparam int          DEPTH       = 256;
    localparam int          QUIET_LIMIT = 4000;
    localparam logic [1:0]  CMD_NOP     = 2'd3;   // unused opcode, no effect
    localparam logic [2:0]  CAP_ADDR    = {dss_pkg::REG_CAPACITY, 2'b00};
    localparam logic [2:0]  SPARE_ADDR  = 3'd4;   // no register here

    typedef struct {
        logic [31:0]      read_data;
        dss_pkg::status_t status;
        logic [8:0]       size_one;
        logic [8:0]       size_two;
        logic             full;
    } outcome_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dss_pkg::PADDR_W-1:0]     paddr;
    logic [dss_pkg::PDATA_W-1:0]     pwdata;
    logic [dss_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dss_pkg::XDATA_W-1:0]     s_tdata;   // [31:0] write_data
    logic [dss_pkg::S_TUSER_W-1:0]   s_tuser;   // [1:0] cmd, [2] stack_select
    logic                            m_tvalid;
    logic                            m_tready;
    logic [dss_pkg::M_TDATA_W-1:0]   m_tdata;   // [31:0] read_data, [40:32] size_one,
                                                // [49:41] size_two, [50] buffer_full
    logic [dss_pkg::M_TUSER_W-1:0]   m_tuser;   // [1:0] status

    // stack model
    logic [31:0]    element_copy [DEPTH];
    int             depth_one;
    int             depth_two;
    int             capacity;

    outcome_t       awaited_outcomes [$];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             quiet_cycles = 0;

    dual_stack_shared_buffer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic outcome_t apply_stack_op(input logic [1:0] op, input logic sel,
                                                input logic [31:0] data);
        outcome_t res;
        bit       was_full;
        bit       was_empty;
        int       top;
        res.read_data = '0;
        res.status    = dss_pkg::ST_DONE;
        was_full  = (depth_one + depth_two) >= capacity;
        was_empty = sel ? (depth_two == 0) : (depth_one == 0);
        case (op)
            dss_pkg::CMD_PUSH:
            begin
                if (was_full)
                    res.status = dss_pkg::ST_FULL;
                else if (!sel)
                begin
                    element_copy[depth_one] = data;
                    depth_one++;
                end
                else
                begin
                    depth_two++;
                    element_copy[capacity - depth_two] = data;
                end
            end
            dss_pkg::CMD_POP, dss_pkg::CMD_PEEK:
            begin
                if (was_empty)
                    res.status = dss_pkg::ST_EMPTY;
                else
                begin
                    top = sel ? (capacity - depth_two) : (depth_one - 1);
                    res.read_data = element_copy[top];
                    if (op == dss_pkg::CMD_POP)
                    begin
                        if (sel)
                            depth_two--;
                        else
                            depth_one--;
                    end
                end
            end
            default: ;
        endcase
        res.size_one = depth_one[8:0];
        res.size_two = depth_two[8:0];
        res.full     = (depth_one + depth_two) >= capacity;
        return res;
    endfunction

    // capacity only changes while both stacks are empty; 0 and oversize saturate
    function automatic void apply_capacity(input logic [31:0] value);
        int v;
        if (depth_one != 0 || depth_two != 0)
            return;
        v = int'(value[8:0]);
        if (v == 0)
            v = 1;
        if (v > DEPTH)
            v = DEPTH;
        capacity = v;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h, got %h", $realtime, field, want, got);
    endtask

    task automatic send_request(input logic [1:0] op, input logic sel,
                                input logic [31:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {sel, op};
        do
            @(posedge clk);
        while (!s_tready);
        awaited_outcomes.push_back(apply_stack_op(op, sel, data));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_outcomes.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr[2] == dss_pkg::REG_CAPACITY)
            apply_capacity(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_capacity_readback();
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(capacity))
            note_mismatch("capacity readback", 32'(capacity), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_stacks();
        while (depth_one > 0)
            send_request(dss_pkg::CMD_POP, 1'b0, $urandom());
        while (depth_two > 0)
            send_request(dss_pkg::CMD_POP, 1'b1, $urandom());
    endtask

    // refusals on empty stacks, the unused opcode, data extremes
    task automatic test_empty_and_opcodes();
        send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
        send_request(dss_pkg::CMD_PEEK, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_NOP,           1'b1, $urandom());
        send_request(dss_pkg::CMD_PUSH, 1'b0, 32'hFFFF_FFFF);
        send_request(dss_pkg::CMD_PUSH, 1'b1, 32'h0000_0000);
        send_request(dss_pkg::CMD_PUSH, 1'b0, $urandom());
        send_request(dss_pkg::CMD_PEEK, 1'b0, 32'h0);
        send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
        send_request(CMD_NOP,           1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_capacity_extremes();
        check_capacity_readback();
        write_reg(CAP_ADDR, 32'hFFFF_FE00);                   // zero saturates to one
        check_capacity_readback();
        send_request(dss_pkg::CMD_PUSH, 1'b1, 32'hA5A5_5A5A);
        send_request(dss_pkg::CMD_PUSH, 1'b0, $urandom());     // refused, full
        send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
        write_reg(CAP_ADDR, 32'd2);
        send_request(dss_pkg::CMD_PUSH, 1'b0, $urandom());
        send_request(dss_pkg::CMD_PUSH, 1'b1, $urandom());     // tops meet
        send_request(dss_pkg::CMD_PUSH, 1'b1, $urandom());
        write_reg(CAP_ADDR, 32'd5);                   // ignored, stacks hold data
        check_capacity_readback();
        send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
        send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
        send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
        write_reg(CAP_ADDR, 32'h0000_01FF);           // oversize saturates
        check_capacity_readback();
        write_reg(SPARE_ADDR, 32'd7);
        check_capacity_readback();
    endtask

    // sender holds off until every result is back, receiver stalls meanwhile
    task automatic test_sender_pause();
        recv_stall_pct = 76;
        send_idle_pct  = 0;
        repeat (12)
            send_request(dss_pkg::CMD_PUSH, 1'($urandom_range(0, 1)), $urandom());
        wait_results_drained();
        repeat (14)
            send_request(dss_pkg::CMD_POP, 1'($urandom_range(0, 1)), 32'h0);
        drain_stacks();
    endtask

    task automatic run_traffic_phase(input int n_items, input int idle_pct,
                                     input int stall_pct, input int cap);
        bit         filling;
        int         roll;
        logic [1:0] op;
        logic       sel;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        drain_stacks();
        write_reg(CAP_ADDR, ($urandom() & ~32'h1FF) | 32'(cap));
        filling = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (depth_one + depth_two >= capacity)
                filling = 1'b0;
            else if (depth_one + depth_two == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 3)
                filling = !filling;
            roll = $urandom_range(0, 99);
            sel  = 1'($urandom_range(0, 1));
            if (roll < 3)
                op = CMD_NOP;
            else if (roll < 7)
                op = 2'($urandom_range(0, 3));
            else if (filling)
                op = (roll < 95) ? dss_pkg::CMD_PUSH :
                     (roll < 98) ? dss_pkg::CMD_POP : dss_pkg::CMD_PEEK;
            else
                op = (roll < 30) ? dss_pkg::CMD_PUSH :
                     (roll < 75) ? dss_pkg::CMD_POP : dss_pkg::CMD_PEEK;
            send_request(op, sel, $urandom());
        end
        // usually lands while data is held, so the write must be ignored
        write_reg(CAP_ADDR, 32'($urandom_range(0, 300)));
        check_capacity_readback();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(160, 0,  0,  256);
        run_traffic_phase(120, 76, 0,  $urandom_range(2, 40));
        run_traffic_phase(120, 0,  76, $urandom_range(1, 24));
        run_traffic_phase(120, 36, 36, $urandom_range(1, 64));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_stacks();
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_outcomes.size() == 0)
                note_mismatch("unexpected result", 32'h0, m_tdata[31:0]);
            else
            begin
                want = awaited_outcomes.pop_front();
                if (m_tdata[31:0] !== want.read_data)
                    note_mismatch("read_data", want.read_data, m_tdata[31:0]);
                if (m_tuser !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[40:32] !== want.size_one)
                    note_mismatch("size_one", 32'(want.size_one), 32'(m_tdata[40:32]));
                if (m_tdata[49:41] !== want.size_two)
                    note_mismatch("size_two", 32'(want.size_two), 32'(m_tdata[49:41]));
                if (m_tdata[50] !== want.full)
                    note_mismatch("buffer_full", 32'(want.full), 32'(m_tdata[50]));
                if (m_tdata[55:51] !== '0)
                    note_mismatch("tdata padding", 32'h0, 32'(m_tdata[55:51]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("dual_stack_shared_buffer: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        depth_one = 0;
        depth_two = 0;
        capacity  = DEPTH;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_opcodes();
        test_capacity_extremes();
        test_sender_pause();
        test_random_traffic();

        wait_results_drained();
        repeat (5)
            @(posedge clk);
        if (awaited_outcomes.size() != 0)
            note_mismatch("results still awaited", 32'h0,
                          32'(awaited_outcomes.size()));
        if (mismatch_count == 0)
            $display("dual_stack_shared_buffer: match");
        else
            $display("dual_stack_shared_buffer: mismatch");
        $finish;
    end

endmodule
